@@ design/des_pkg.sv @@
// Package: DES tables, round state type and permutation functions
`default_nettype none
package des_pkg;

    localparam int ROUND_COUNT = 16;
    localparam int HALF_BITS   = 28;

    typedef struct packed {
        logic [31:0]          l;
        logic [31:0]          r;
        logic [HALF_BITS-1:0] c;
        logic [HALF_BITS-1:0] d;
    } t_des_state;

    localparam logic [6:0] IP_TBL [64] = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };

    localparam logic [6:0] FP_TBL [64] = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };

    localparam logic [5:0] E_TBL [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1 };

    localparam logic [5:0] P_TBL [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25 };

    localparam logic [6:0] PC1_TBL [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };

    localparam logic [5:0] PC2_TBL [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32 };

    localparam int ROT_TBL [ROUND_COUNT] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] S_TBL [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

    function automatic logic [63:0] ip_perm(input logic [63:0] w);
        logic [63:0] o;
        o = '0;
        for (int i = 0; i < 64; i++) begin
            o[6'(63 - i)] = w[6'(64 - int'(IP_TBL[i]))];
        end
        return o;
    endfunction

    function automatic logic [63:0] fp_perm(input logic [63:0] w);
        logic [63:0] o;
        o = '0;
        for (int i = 0; i < 64; i++) begin
            o[6'(63 - i)] = w[6'(64 - int'(FP_TBL[i]))];
        end
        return o;
    endfunction

    function automatic logic [55:0] pc1_perm(input logic [63:0] w);
        logic [55:0] o;
        o = '0;
        for (int i = 0; i < 56; i++) begin
            o[6'(55 - i)] = w[6'(64 - int'(PC1_TBL[i]))];
        end
        return o;
    endfunction

    function automatic logic [47:0] pc2_perm(input logic [55:0] w);
        logic [47:0] o;
        o = '0;
        for (int i = 0; i < 48; i++) begin
            o[6'(47 - i)] = w[6'(56 - int'(PC2_TBL[i]))];
        end
        return o;
    endfunction

    function automatic logic [47:0] e_expand(input logic [31:0] w);
        logic [47:0] o;
        o = '0;
        for (int i = 0; i < 48; i++) begin
            o[6'(47 - i)] = w[5'(32 - int'(E_TBL[i]))];
        end
        return o;
    endfunction

    function automatic logic [31:0] p_perm(input logic [31:0] w);
        logic [31:0] o;
        o = '0;
        for (int i = 0; i < 32; i++) begin
            o[5'(31 - i)] = w[5'(32 - int'(P_TBL[i]))];
        end
        return o;
    endfunction

    function automatic logic [31:0] sbox_sub(input logic [47:0] x);
        logic [31:0] o;
        logic [5:0]  v;
        o = '0;
        for (int b = 0; b < 8; b++) begin
            v = x[47 - 6 * b -: 6];
            o[31 - 4 * b -: 4] = S_TBL[3'(b)][{v[5], v[0], v[4:1]}];
        end
        return o;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] sub);
        return p_perm(sbox_sub(e_expand(r) ^ sub));
    endfunction

endpackage
`default_nettype wire

@@ design/des_round_cell.sv @@
// One DES round cell: key rotation, subkey, Feistel function, holding register
`default_nettype none
module des_round_cell
    import des_pkg::*;
#(
    parameter int ROUND_IDX = 0
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_des_state i_data,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_des_state      o_data
);

    localparam int SHIFT = ROT_TBL[ROUND_IDX];

    logic       r_valid;
    t_des_state r_data;
    t_des_state n_data;
    logic [47:0] subkey;

    always_comb begin
        n_data.c = (i_data.c << SHIFT) | (i_data.c >> (HALF_BITS - SHIFT));
        n_data.d = (i_data.d << SHIFT) | (i_data.d >> (HALF_BITS - SHIFT));
        subkey   = pc2_perm({n_data.c, n_data.d});
        n_data.l = i_data.r;
        n_data.r = i_data.l ^ feistel(i_data.r, subkey);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // advance only when a word moves in
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

@@ design/des_block_encrypt_core.sv @@
// DES encryption top level: initial permutations, sixteen round cells, final permutation
// Each accepted word is registered in turn by all sixteen round cells before its output handshake.
// Throughput: one word per cycle while the output is not stalled; each of the sixteen round cells holds one word.
// A stalled output holds the last cell and every full cell behind it; cells before a bubble keep filling it.
// Reset (synchronous, active low) clears every cell's valid bit; data is not reset.
`default_nettype none
module des_block_encrypt_core
    import des_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_plain_block,
    input  wire logic [63:0] i_cipher_key,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_cipher_block
);

    logic       valid [ROUND_COUNT+1];
    logic       ready [ROUND_COUNT+1];
    t_des_state data  [ROUND_COUNT+1];
    logic [63:0] blk;
    logic [55:0] cd;

    always_comb begin
        blk = ip_perm(i_plain_block);
        cd  = pc1_perm(i_cipher_key);
        data[0].l = blk[63:32];
        data[0].r = blk[31:0];
        data[0].c = cd[55:28];
        data[0].d = cd[27:0];
    end

    assign valid[0]           = i_in_valid;
    assign o_in_ready         = ready[0];
    assign ready[ROUND_COUNT] = i_out_ready;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        des_round_cell #(
            .ROUND_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(valid[g]),
            .o_ready(ready[g]),
            .i_data (data[g]),
            .o_valid(valid[g+1]),
            .i_ready(ready[g+1]),
            .o_data (data[g+1])
        );
    end

    assign o_out_valid    = valid[ROUND_COUNT];
    assign o_cipher_block = fp_perm({data[ROUND_COUNT].r, data[ROUND_COUNT].l});

endmodule
`default_nettype wire

@@ design/des_checker.sv @@
// Port checker for the DES encryption core, bound to the top level
`default_nettype none
module des_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic [63:0] i_plain_block,
    input wire logic [63:0] i_cipher_key,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_cipher_block
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_cipher_block))
        else $error("stalled output word dropped or changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_plain_block) && $stable(i_cipher_key))
        else $error("stalled input word dropped or changed");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output drains");

endmodule

bind des_block_encrypt_core des_checker u_des_checker (.*);
`default_nettype wire
